// ----- rtl/core/yinp_pkg.sv -----
// Shared constants for the YIN pitch detector.
`default_nettype none
package yinp_pkg;
    localparam int WINDOW_DEF      = 2048;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int THR_W   = 17;
    localparam int SR_W    = 18;
    localparam int PITCH_W = 18;
    localparam int LAG_W   = 19;
    localparam int CM_W    = 20;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 18;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd1;

    localparam logic [THR_W-1:0] THR_RESET = 17'd9830;
    localparam logic [SR_W-1:0]  SR_RESET  = 18'd44100;

    localparam logic [CM_W-1:0]  CM_ONE  = 20'h10000;
    localparam logic [CM_W-1:0]  CM_MAX  = 20'hFFFFF;
    localparam logic [LAG_W-1:0] LAG_MAX = 19'h7FFFF;

    // pitch limits in Q.4 Hz
    localparam int PITCH_LO = 320;
    localparam int PITCH_HI = 160000;

    // quotient bits of the shared divider
    localparam int DIV_QB = 29;
endpackage
`default_nettype wire

// ----- rtl/core/yinp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module yinp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/core/yinp_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module yinp_div #(
    parameter int NW  = 69,
    parameter int DDW = 53,
    parameter int QB  = 29
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [NW-1:0]  i_num,
    input  wire logic [DDW-1:0] i_den,
    output logic                o_done,
    output logic [QB-1:0]       o_quo
);
    localparam int CMPW = (NW > DDW + QB - 1) ? NW : DDW + QB - 1;
    localparam int CNTW = $clog2(QB + 1);

    logic [CMPW-1:0] r_rem;
    logic [CMPW-1:0] r_ds;
    logic [QB-1:0]   r_q;
    logic [CNTW-1:0] r_cnt;
    logic            r_done;
    logic            ge;

    assign ge     = r_rem >= r_ds;
    assign o_done = r_done;
    assign o_quo  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNTW'(QB);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= CMPW'(i_num);
            r_ds  <= CMPW'(i_den) << (QB - 1);
            r_q   <= '0;
        end else if (r_cnt != '0) begin
            if (ge) begin
                r_rem <= r_rem - r_ds;
            end
            r_q  <= {r_q[QB-2:0], ge};
            r_ds <= r_ds >> 1;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/yinp_front.sv -----
// Input side: sample capture, frame queue and configuration registers.
`default_nettype none
module yinp_front #(
    parameter int WINDOW      = yinp_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = yinp_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]     i_sample,
    input  wire logic                              i_last,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [yinp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [yinp_pkg::CFG_DAT_W-1:0]    i_cfg_data,
    input  wire logic                              i_back_busy,
    input  wire logic                              i_job_pop,
    output logic                                   o_job_valid,
    output logic [$clog2(WINDOW+1)-1:0]            o_job_n,
    output logic                                   o_we,
    output logic [$clog2(WINDOW)-1:0]              o_waddr,
    output logic [SAMPLE_BITS-1:0]                 o_wdata,
    output logic [yinp_pkg::THR_W-1:0]             o_threshold,
    output logic [yinp_pkg::SR_W-1:0]              o_sample_rate
);
    import yinp_pkg::*;

    localparam int CW = $clog2(WINDOW + 1);
    localparam int AW = $clog2(WINDOW);

    logic [CW-1:0] r_cnt;
    logic          r_job_valid;
    logic [CW-1:0] r_job_n;
    logic [THR_W-1:0] r_threshold;
    logic [SR_W-1:0]  r_sample_rate;
    logic          accept;
    logic          room;

    // frame samples may not overwrite a frame still under analysis
    assign o_stall = r_job_valid || i_back_busy;
    assign accept  = i_valid && !o_stall;
    assign room    = r_cnt < CW'(WINDOW);

    assign o_we    = accept && room;
    assign o_waddr = r_cnt[AW-1:0];
    assign o_wdata = i_sample;

    assign o_job_valid   = r_job_valid;
    assign o_job_n       = r_job_n;
    assign o_cfg_ready   = 1'b1;
    assign o_threshold   = r_threshold;
    assign o_sample_rate = r_sample_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt         <= '0;
            r_job_valid   <= 1'b0;
            r_threshold   <= THR_RESET;
            r_sample_rate <= SR_RESET;
        end else begin
            if (i_job_pop) begin
                r_job_valid <= 1'b0;
            end
            if (accept) begin
                if (i_last) begin
                    r_cnt       <= '0;
                    r_job_valid <= 1'b1;
                    r_job_n     <= room ? r_cnt + 1'b1 : r_cnt;
                end else if (room) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_THRESHOLD:   r_threshold   <= i_cfg_data[THR_W-1:0];
                    REG_SAMPLE_RATE: r_sample_rate <= i_cfg_data[SR_W-1:0];
                    default: ;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/yinp_back.sv -----
// Analysis sequencer: difference, normalisation, minimum search, refinement, frequency.
`default_nettype none
module yinp_back #(
    parameter int WINDOW      = yinp_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = yinp_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_job_valid,
    input  wire logic [$clog2(WINDOW+1)-1:0]     i_job_n,
    output logic                                 o_job_pop,
    output logic                                 o_busy,
    output logic [$clog2(WINDOW)-1:0]            o_sa_addr,
    output logic [$clog2(WINDOW)-1:0]            o_sb_addr,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_sa_data,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_sb_data,
    input  wire logic [yinp_pkg::THR_W-1:0]      i_threshold,
    input  wire logic [yinp_pkg::SR_W-1:0]       i_sample_rate,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic                                 o_pitched,
    output logic [yinp_pkg::PITCH_W-1:0]         o_pitch_hz,
    output logic [yinp_pkg::LAG_W-1:0]           o_lag
);
    import yinp_pkg::*;

    localparam int AW   = $clog2(WINDOW);
    localparam int HAW  = AW - 1;
    localparam int HW   = $clog2(WINDOW / 2 + 1);
    localparam int CW   = $clog2(WINDOW + 1);
    localparam int PW   = 2 * SAMPLE_BITS;
    localparam int DW   = PW + HAW;
    localparam int SW   = DW + HAW;
    localparam int MW   = DW + HAW;
    localparam int DNW  = (MW + 16 > 30) ? MW + 16 : 30;
    localparam int DDW  = (SW > 24) ? SW : 24;
    localparam int FW   = LAG_W + 18;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DIFF     = 5'd1;
    localparam logic [4:0] S_DRAIN    = 5'd2;
    localparam logic [4:0] S_CM_RD    = 5'd3;
    localparam logic [4:0] S_CM_WAIT  = 5'd4;
    localparam logic [4:0] S_CM_MUL   = 5'd5;
    localparam logic [4:0] S_CM_CHK   = 5'd6;
    localparam logic [4:0] S_CM_DIV   = 5'd7;
    localparam logic [4:0] S_SRCH     = 5'd8;
    localparam logic [4:0] S_SRCH_END = 5'd9;
    localparam logic [4:0] S_REF      = 5'd10;
    localparam logic [4:0] S_REF_DIV  = 5'd11;
    localparam logic [4:0] S_REF_LAG  = 5'd12;
    localparam logic [4:0] S_FRQ_MUL  = 5'd13;
    localparam logic [4:0] S_FRQ_CMP  = 5'd14;
    localparam logic [4:0] S_FRQ_DIV  = 5'd15;
    localparam logic [4:0] S_DONE     = 5'd16;

    logic [4:0]    r_state;
    logic [4:0]    n_state;
    logic [HW-1:0] r_half;
    logic [HW-1:0] r_tau;
    logic [HW-1:0] r_i;

    // difference pipeline
    logic                          r_v1, r_f1, r_l1;
    logic [HAW-1:0]                r_t1;
    logic                          r_v2, r_f2, r_l2;
    logic [HAW-1:0]                r_t2;
    logic signed [SAMPLE_BITS:0]   r_dif;
    logic                          r_v3, r_f3, r_l3;
    logic [HAW-1:0]                r_t3;
    logic [PW-1:0]                 r_sq;
    logic [DW-1:0]                 r_acc;
    logic [DW-1:0]                 acc_next;
    logic signed [2*SAMPLE_BITS+1:0] sq_full;

    // normalisation
    logic [DW-1:0] r_dv;
    logic [SW-1:0] r_sum;
    logic [MW-1:0] r_num;
    logic          sat;
    logic          cm_adv;
    logic [CM_W-1:0] cm_val;

    // search
    logic [HW-1:0]   r_k;
    logic            r_rv;
    logic [HW-1:0]   r_rk;
    logic [CM_W-1:0] r_w0, r_w1;
    logic            r_found, r_have;
    logic [HAW-1:0]  r_best;
    logic [CM_W-1:0] r_bval, r_a, r_b, r_g;
    logic [CM_W-1:0] cur;
    logic            is_min;

    // refinement
    logic signed [23:0] den_s;
    logic signed [29:0] num_s;
    logic [23:0]        den_mag;
    logic [29:0]        num_mag;
    logic               r_neg;
    logic signed [31:0] off_s;
    logic signed [31:0] lag_raw;
    logic [LAG_W-1:0]   r_lag;
    logic [FW-1:0]      r_plo, r_phi;
    logic [FW-1:0]      scaled;

    // results and output register
    logic               r_res_p;
    logic [PITCH_W-1:0] r_res_hz;
    logic [LAG_W-1:0]   r_res_lag;
    logic               r_ovalid;
    logic               r_opitched;
    logic [PITCH_W-1:0] r_ohz;
    logic [LAG_W-1:0]   r_olag;
    logic               out_free;

    // diff RAM and divider
    logic              d_we;
    logic [HAW-1:0]    d_waddr, d_raddr;
    logic [DW-1:0]     d_wdata, d_rdata;
    logic              div_start, div_done;
    logic [DNW-1:0]    div_num;
    logic [DDW-1:0]    div_den;
    logic [DIV_QB-1:0] div_q;

    yinp_ram #(.WIDTH(DW), .DEPTH(WINDOW / 2)) u_dram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    yinp_div #(.NW(DNW), .DDW(DDW), .QB(DIV_QB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    assign o_busy    = r_state != S_IDLE;
    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign out_free  = !r_ovalid || !i_stall;

    assign o_sa_addr = AW'(r_i);
    assign o_sb_addr = AW'(r_i) + AW'(r_tau);

    assign sq_full  = r_dif * r_dif;
    assign acc_next = (r_f3 ? '0 : r_acc) + DW'(r_sq);

    assign sat = (SW + 4)'(r_num) >= ((SW + 4)'(r_sum) << 4);
    assign cm_val = (r_sum == '0) ? CM_ONE : (sat ? CM_MAX : div_q[CM_W-1:0]);
    assign cm_adv = ((r_state == S_CM_CHK) && ((r_sum == '0) || sat)) ||
                    ((r_state == S_CM_DIV) && div_done);

    assign cur    = d_rdata[CM_W-1:0];
    assign is_min = r_rv && (r_rk >= HW'(3)) && !r_found &&
                    (r_w1 < r_w0) && (r_w1 < cur);

    assign den_s   = ($signed({4'b0, r_a}) + $signed({4'b0, r_g})
                     - ($signed({4'b0, r_b}) <<< 1)) <<< 1;
    assign num_s   = ($signed({10'b0, r_a}) - $signed({10'b0, r_g})) <<< 8;
    assign den_mag = den_s[23] ? 24'(-den_s) : 24'(den_s);
    assign num_mag = num_s[29] ? 30'(-num_s) : 30'(num_s);
    assign off_s   = r_neg ? -$signed({3'b0, div_q}) : $signed({3'b0, div_q});
    assign scaled  = FW'({i_sample_rate, 12'b0});

    always_comb begin
        d_we    = 1'b0;
        d_waddr = r_t3;
        d_wdata = acc_next;
        d_raddr = r_tau[HAW-1:0];
        if (r_v3 && r_l3) begin
            d_we = 1'b1;
        end
        if (cm_adv) begin
            d_we    = 1'b1;
            d_waddr = r_tau[HAW-1:0];
            d_wdata = DW'(cm_val);
        end
        if (r_state == S_SRCH) begin
            d_raddr = r_k[HAW-1:0];
        end
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = DNW'({r_num, 16'b0});
        div_den   = DDW'(r_sum);
        case (r_state)
            S_CM_CHK: begin
                div_start = (r_sum != '0) && !sat;
            end
            S_REF: begin
                div_start = r_have && (den_s != '0);
                div_num   = DNW'(num_mag);
                div_den   = DDW'(den_mag);
            end
            S_FRQ_CMP: begin
                div_start = (scaled >= r_plo) && (scaled <= r_phi);
                div_num   = DNW'(scaled);
                div_den   = DDW'(r_lag);
            end
            default: ;
        endcase
    end

    always_comb begin
        lag_raw = $signed({{(24 - HAW){1'b0}}, r_best, 8'b0});
        if (!(r_neg && div_q == '0) && r_state == S_REF_LAG) begin
            lag_raw = lag_raw;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_state = (i_job_n[CW-1:1] < (CW - 1)'(4)) ? S_DONE : S_DIFF;
                end
            end
            S_DIFF: begin
                if (r_i == r_half - 1'b1 && r_tau == r_half - 1'b1) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!(r_v1 || r_v2 || r_v3)) begin
                    n_state = S_CM_RD;
                end
            end
            S_CM_RD:   n_state = S_CM_WAIT;
            S_CM_WAIT: n_state = S_CM_MUL;
            S_CM_MUL:  n_state = S_CM_CHK;
            S_CM_CHK, S_CM_DIV: begin
                if (r_state == S_CM_CHK && div_start) begin
                    n_state = S_CM_DIV;
                end else if (cm_adv) begin
                    n_state = (r_tau == r_half - 1'b1) ? S_SRCH : S_CM_RD;
                end
            end
            S_SRCH: begin
                if (r_k == r_half - 1'b1) begin
                    n_state = S_SRCH_END;
                end
            end
            S_SRCH_END: n_state = S_REF;
            S_REF: begin
                if (!r_have) begin
                    n_state = S_DONE;
                end else if (div_start) begin
                    n_state = S_REF_DIV;
                end else begin
                    n_state = S_REF_LAG;
                end
            end
            S_REF_DIV: begin
                if (div_done) begin
                    n_state = S_REF_LAG;
                end
            end
            S_REF_LAG: n_state = S_FRQ_MUL;
            S_FRQ_MUL: n_state = (r_lag == '0) ? S_DONE : S_FRQ_CMP;
            S_FRQ_CMP: n_state = div_start ? S_FRQ_DIV : S_DONE;
            S_FRQ_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_v3     <= 1'b0;
            r_rv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_v1    <= r_state == S_DIFF;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_rv    <= r_state == S_SRCH;
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        // difference pipeline
        r_f1  <= r_i == '0;
        r_l1  <= r_i == r_half - 1'b1;
        r_t1  <= r_tau[HAW-1:0];
        r_f2  <= r_f1;
        r_l2  <= r_l1;
        r_t2  <= r_t1;
        r_dif <= (SAMPLE_BITS + 1)'(i_sa_data) - (SAMPLE_BITS + 1)'(i_sb_data);
        r_f3  <= r_f2;
        r_l3  <= r_l2;
        r_t3  <= r_t2;
        r_sq  <= sq_full[PW-1:0];
        if (r_v3) begin
            r_acc <= acc_next;
        end

        case (r_state)
            S_IDLE: begin
                r_half    <= HW'(i_job_n >> 1);
                r_i       <= '0;
                r_tau     <= '0;
                r_have    <= 1'b0;
                r_found   <= 1'b0;
                r_res_p   <= 1'b0;
                r_res_hz  <= '0;
                r_res_lag <= '0;
            end
            S_DIFF: begin
                if (r_i == r_half - 1'b1) begin
                    r_i   <= '0;
                    r_tau <= r_tau + 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
            S_DRAIN: begin
                r_tau <= HW'(1);
                r_sum <= '0;
            end
            S_CM_WAIT: begin
                r_dv  <= d_rdata;
                r_sum <= r_sum + SW'(d_rdata);
            end
            S_CM_MUL: begin
                r_num <= MW'(r_dv) * MW'(r_tau);
            end
            default: ;
        endcase

        if (cm_adv) begin
            r_tau <= r_tau + 1'b1;
            r_k   <= HW'(1);
        end

        // minimum search over a sliding window of three
        if (r_state == S_SRCH) begin
            r_k  <= r_k + 1'b1;
            r_rk <= r_k;
        end
        if (r_rv) begin
            r_w0 <= r_w1;
            r_w1 <= cur;
        end
        if (is_min) begin
            if (r_w1 < {3'b0, i_threshold}) begin
                r_found <= 1'b1;
                r_have  <= 1'b1;
                r_best  <= HAW'(r_rk - 1'b1);
                r_a     <= r_w0;
                r_b     <= r_w1;
                r_g     <= cur;
            end else if (!r_have || r_w1 < r_bval) begin
                r_have <= 1'b1;
                r_bval <= r_w1;
                r_best <= HAW'(r_rk - 1'b1);
                r_a    <= r_w0;
                r_b    <= r_w1;
                r_g    <= cur;
            end
        end

        // parabolic refinement and frequency
        if (r_state == S_REF) begin
            r_neg <= (num_s[29] != den_s[23]) && (den_s != '0);
        end
        if (r_state == S_REF_LAG) begin
            if (lag_raw + ((r_neg || div_q != '0) ? off_s : 32'sd0) < 0) begin
                r_lag <= '0;
            end else if (lag_raw + off_s > $signed({13'b0, LAG_MAX})) begin
                r_lag <= LAG_MAX;
            end else begin
                r_lag <= LAG_W'(lag_raw + off_s);
            end
        end
        if (r_state == S_REF && r_have && den_s == '0) begin
            r_neg <= 1'b0;
        end
        if (r_state == S_FRQ_MUL) begin
            r_res_lag <= r_lag;
            r_plo     <= FW'(PITCH_LO) * FW'(r_lag);
            r_phi     <= FW'(PITCH_HI) * FW'(r_lag);
        end
        if (r_state == S_FRQ_DIV && div_done) begin
            r_res_p  <= 1'b1;
            r_res_hz <= div_q[PITCH_W-1:0];
        end

        if (r_state == S_DONE && out_free) begin
            r_opitched <= r_res_p;
            r_ohz      <= r_res_hz;
            r_olag     <= r_res_lag;
        end
    end

    assign o_valid    = r_ovalid;
    assign o_pitched  = r_opitched;
    assign o_pitch_hz = r_ohz;
    assign o_lag      = r_olag;
endmodule
`default_nettype wire

// ----- rtl/core/yin_pitch_detector.sv -----
// YIN pitch detector: usage
// Input channel: one sample a beat on i_sample, i_last on the final sample
// of a frame. Samples past WINDOW are dropped but i_last still ends the
// frame. One result beat (o_pitched, o_pitch_hz in Q.4, o_lag in Q.8)
// follows every frame. Configuration (threshold, sample rate) is written on
// the cfg channel, index 0 or 1; the user must write it only while no frame
// is in flight, as the block itself does not enforce this. Samples are taken
// one a cycle while a frame is being collected. Once a frame ends, input
// stalls during its analysis: the square-and-add pipeline does one product
// a cycle, then the divider runs at most once per lag. Reset clears the
// sample count, queue, output valid and the registers to threshold 9830 and
// 44100 Hz; the memories need no clearing. A stalled result holds in the
// output register; the next frame may still be collected, and its analysis
// waits only to hand over its result.
`default_nettype none
module yin_pitch_detector #(
    parameter int WINDOW      = yinp_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = yinp_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]  i_sample,
    input  wire logic                           i_last,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [yinp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [yinp_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic                                o_pitched,
    output logic [yinp_pkg::PITCH_W-1:0]        o_pitch_hz,
    output logic [yinp_pkg::LAG_W-1:0]          o_lag
);
    import yinp_pkg::*;

    localparam int AW = $clog2(WINDOW);
    localparam int CW = $clog2(WINDOW + 1);

    logic                   back_busy, job_pop, job_valid;
    logic [CW-1:0]          job_n;
    logic                   s_we;
    logic [AW-1:0]          s_waddr, sa_addr, sb_addr;
    logic [SAMPLE_BITS-1:0] s_wdata, sa_data, sb_data;
    logic [THR_W-1:0]       threshold;
    logic [SR_W-1:0]        sample_rate;

    yinp_front #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sample      (i_sample),
        .i_last        (i_last),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_back_busy   (back_busy),
        .i_job_pop     (job_pop),
        .o_job_valid   (job_valid),
        .o_job_n       (job_n),
        .o_we          (s_we),
        .o_waddr       (s_waddr),
        .o_wdata       (s_wdata),
        .o_threshold   (threshold),
        .o_sample_rate (sample_rate)
    );

    // two copies give the two sample reads per cycle
    yinp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW)) u_sram_a (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (sa_addr),
        .o_rdata (sa_data)
    );

    yinp_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(WINDOW)) u_sram_b (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (sb_addr),
        .o_rdata (sb_data)
    );

    yinp_back #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (job_valid),
        .i_job_n       (job_n),
        .o_job_pop     (job_pop),
        .o_busy        (back_busy),
        .o_sa_addr     (sa_addr),
        .o_sb_addr     (sb_addr),
        .i_sa_data     ($signed(sa_data)),
        .i_sb_data     ($signed(sb_data)),
        .i_threshold   (threshold),
        .i_sample_rate (sample_rate),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pitched     (o_pitched),
        .o_pitch_hz    (o_pitch_hz),
        .o_lag         (o_lag)
    );
endmodule
`default_nettype wire

// ----- dv/yin_pitch_detector_tb.sv -----
// Self-checking testbench for the YIN pitch detector: frame stimulus, pitch predictor and scoreboard.
`default_nettype none

class pitch_scoreboard;
    int                sample_mem [2048];
    longint unsigned   diff_mem [1024];
    int unsigned       fill;
    logic [16:0]       thr;
    logic [17:0]       rate;
    logic [37:0]       pitch_due [$];
    int unsigned       errors;
    int unsigned       frames;
    int unsigned       pitched_seen;

    function new();
        fill = 0;
        thr = yinp_pkg::THR_RESET;
        rate = yinp_pkg::SR_RESET;
        errors = 0;
        frames = 0;
        pitched_seen = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [17:0] val);
        if (idx == yinp_pkg::REG_THRESHOLD)
            thr = val[16:0];
        else if (idx == yinp_pkg::REG_SAMPLE_RATE)
            rate = val;
    endfunction

    // Q.16 quotient, truncated and saturated at just under 16.0
    function longint unsigned cmnd_ratio(longint unsigned num, longint unsigned den);
        longint unsigned q, r;
        q = num / den;
        r = num % den;
        if (q >= 16)
            return yinp_pkg::CM_MAX;
        for (int k = 0; k < 16; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        return (q > yinp_pkg::CM_MAX) ? yinp_pkg::CM_MAX : q;
    endfunction

    function logic [37:0] pitch_of_frame(int unsigned n);
        int unsigned     half;
        longint unsigned acc, run, c, best_val, scaled;
        longint          dlt, a, b, g, den, lagv;
        int              best;
        bit              found;
        logic [17:0]     hz;
        logic            hit;
        half = n / 2;
        if (half > 1024)
            half = 1024;
        best = -1;
        found = 0;
        best_val = 0;
        run = 0;
        hz = '0;
        hit = 0;
        for (int t = 0; t < half; t++) begin
            acc = 0;
            for (int i = 0; i < half; i++) begin
                dlt = longint'(sample_mem[i]) - longint'(sample_mem[(i + t) & 2047]);
                acc += longint'(dlt * dlt);
            end
            diff_mem[t] = acc;
        end
        if (half > 0)
            diff_mem[0] = yinp_pkg::CM_ONE;
        for (int t = 1; t < half; t++) begin
            run += diff_mem[t];
            diff_mem[t] = (run > 0) ? cmnd_ratio(diff_mem[t] * t, run) : yinp_pkg::CM_ONE;
        end
        for (int t = 2; t + 1 < half; t++) begin
            c = diff_mem[t];
            if (c < diff_mem[t-1] && c < diff_mem[t+1]) begin
                if (c < thr) begin
                    best = t;
                    found = 1;
                    break;
                end
                if (!found || c < best_val) begin
                    found = 1;
                    best_val = c;
                    best = t;
                end
            end
        end
        if (!found)
            return '0;
        a = diff_mem[best-1];
        b = diff_mem[best];
        g = diff_mem[best+1];
        den = 2 * (a - 2 * b + g);
        lagv = longint'(best) * 256;
        if (den != 0)
            lagv += ((a - g) * 256) / den;
        if (lagv < 0)
            lagv = 0;
        if (lagv > longint'(yinp_pkg::LAG_MAX))
            lagv = yinp_pkg::LAG_MAX;
        if (lagv != 0) begin
            scaled = longint'(rate) << 12;
            if (scaled >= yinp_pkg::PITCH_LO * lagv && scaled <= yinp_pkg::PITCH_HI * lagv) begin
                hit = 1;
                hz = scaled / lagv;
            end
        end
        return {hit, hz, lagv[18:0]};
    endfunction

    function void take_sample(logic signed [15:0] s, logic last);
        if (fill < 2048) begin
            sample_mem[fill] = s;
            fill++;
        end
        if (last) begin
            pitch_due.push_back(pitch_of_frame(fill));
            fill = 0;
            frames++;
        end
    endfunction

    function void check_result(logic p, logic [17:0] hz, logic [18:0] lag);
        logic [37:0] exp_v;
        if (pitch_due.size() == 0) begin
            $display("%0t: result beat with nothing expected: pitched %0d hz %0d lag %0d",
                     $time, p, hz, lag);
            errors++;
            return;
        end
        exp_v = pitch_due.pop_front();
        if (p !== exp_v[37]) begin
            $display("%0t: pitched expected %0d actual %0d", $time, exp_v[37], p);
            errors++;
        end
        if (hz !== exp_v[36:19]) begin
            $display("%0t: pitch_hz expected %0d actual %0d", $time, exp_v[36:19], hz);
            errors++;
        end
        if (lag !== exp_v[18:0]) begin
            $display("%0t: lag expected %0d actual %0d", $time, exp_v[18:0], lag);
            errors++;
        end
        if (p === 1'b1)
            pitched_seen++;
    endfunction
endclass

module yin_pitch_detector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               o_stall;
    logic signed [15:0] i_sample = '0;
    logic               i_last = 0;
    logic               i_cfg_valid = 0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index = '0;
    logic [17:0]        i_cfg_data = '0;
    logic               o_valid;
    logic               i_stall = 0;
    logic               o_pitched;
    logic [17:0]        o_pitch_hz;
    logic [18:0]        o_lag;

    pitch_scoreboard sb = new();
    bit          calm = 0;
    bit          hold_req = 0;
    int unsigned n_items = 0;
    logic signed [15:0] frame_buf [$];

    yin_pitch_detector dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_sample(i_sample), .i_last(i_last),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_pitched(o_pitched), .o_pitch_hz(o_pitch_hz), .o_lag(o_lag)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #200_000_000;
        $display("status: fail");
        $finish;
    end

    // result side: random stall, one long hold-off on request
    initial begin
        int unsigned held;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && held == 0) begin
                i_stall <= 1;
                repeat (4000) @(posedge i_clk);
                held = 1;
            end
            i_stall <= !calm && $urandom_range(99) < 22;
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_pitched, o_pitch_hz, o_lag);

    task automatic send_beat(logic signed [15:0] s, logic l);
        while (!calm && $urandom_range(99) < 22) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_sample <= s;
        i_last <= l;
        do @(posedge i_clk); while (o_stall);
        sb.take_sample(s, l);
        n_items++;
    endtask

    task automatic send_frame();
        foreach (frame_buf[k])
            send_beat(frame_buf[k], k == frame_buf.size() - 1);
        frame_buf.delete();
    endtask

    task automatic write_reg(logic [1:0] idx, logic [17:0] val);
        i_valid <= 0;
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        i_cfg_valid <= 0;
    endtask

    task automatic drain();
        i_valid <= 0;
        while (sb.pitch_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // periodic tone with random shape, period and noise, or silence, or plain noise
    task automatic build_frame(int unsigned len);
        int unsigned per, shape, amp, noise;
        int v;
        per = $urandom_range(2, (len > 8) ? len / 3 : 3);
        shape = $urandom_range(4);
        amp = $urandom_range(32767);
        noise = $urandom_range(3) == 0 ? $urandom_range(4000) : 0;
        for (int k = 0; k < len; k++) begin
            case (shape)
                0: v = (k % per) * 2 * amp / per - amp;
                1: v = (k % per) < per / 2 ? amp : -amp;
                2: v = 0;
                default: v = $signed(16'($urandom));
            endcase
            if (noise != 0)
                v += int'($urandom_range(2 * noise)) - int'(noise);
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            frame_buf.push_back(16'(v));
        end
    endtask

    initial begin
        int unsigned len, frame_no;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: lone sample, short silent frame, extremes square, silent frame
        write_reg(yinp_pkg::REG_THRESHOLD, yinp_pkg::THR_RESET);
        write_reg(yinp_pkg::REG_SAMPLE_RATE, yinp_pkg::SR_RESET);
        write_reg(2'd2, 18'h3FFFF);
        write_reg(2'd3, 18'h15555);
        frame_buf.push_back(16'sh7FFF);
        send_frame();
        repeat (4) frame_buf.push_back('0);
        send_frame();
        for (int k = 0; k < 12; k++)
            frame_buf.push_back((k % 4) < 2 ? 16'sh8000 : 16'sh7FFF);
        send_frame();
        repeat (8) frame_buf.push_back('0);
        send_frame();
        drain();

        frame_no = 0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(yinp_pkg::REG_THRESHOLD, 18'd0);
                    write_reg(yinp_pkg::REG_SAMPLE_RATE, 18'd8000);
                end
                1: begin
                    write_reg(yinp_pkg::REG_THRESHOLD, 18'd65536);
                    write_reg(yinp_pkg::REG_SAMPLE_RATE, 18'd192000);
                end
                2: begin
                    write_reg(yinp_pkg::REG_THRESHOLD, 18'($urandom));
                    write_reg(yinp_pkg::REG_SAMPLE_RATE, 18'($urandom_range(8000, 192000)));
                end
                default: begin
                    write_reg(yinp_pkg::REG_THRESHOLD, 18'($urandom_range(65536)));
                    write_reg(yinp_pkg::REG_SAMPLE_RATE, 18'($urandom_range(8000, 192000)));
                end
            endcase
            for (int f = 0; f < 12; f++) begin
                calm = (ph == 2);
                if (ph == 1 && f == 2)
                    hold_req = 1;
                if (ph == 3 && f == 5)
                    len = 2060; // overlong frame, tail is dropped
                else if ($urandom_range(9) == 0)
                    len = $urandom_range(1, 7);
                else if ($urandom_range(4) == 0)
                    len = $urandom_range(80, 300);
                else
                    len = $urandom_range(8, 64);
                build_frame(len);
                send_frame();
                frame_no++;
            end
            calm = 0;
            drain();
        end

        repeat (200) @(posedge i_clk);
        $display("covered %0d sample beats in %0d frames, %0d pitched results",
                 n_items, sb.frames, sb.pitched_seen);
        if (sb.errors == 0 && sb.pitch_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

`default_nettype wire
